// File: hw/rtl/sslsm_pkg.sv
// Shared types and constants for the servo soft-limit safety monitor.
// No dependencies; used by every other file of the block.
`default_nettype none

package sslsm_pkg;

  localparam int SERVO_COUNT = 6;

  localparam int CMD_W      = 3;
  localparam int IDX_W      = 3;
  localparam int POS_W      = 16;
  localparam int LIMIT_W    = 12;
  localparam int TICK_W     = 32;
  localparam int HALF_W     = 16;
  localparam int PHASE_W    = 10;
  localparam int STATUS_W   = 2;
  localparam int PROD_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [POS_W-1:0] LIMIT_FLOOR = POS_W'(500);
  localparam logic [POS_W-1:0] LIMIT_CEIL  = POS_W'(2500);

  localparam int ERR_LOW_PCT  = 80;
  localparam int ERR_HIGH_PCT = 120;
  localparam int PCT_SCALE    = 100;

  localparam logic [PHASE_W-1:0] FLASH_PERIOD    = PHASE_W'(1000);
  localparam logic [PHASE_W-1:0] FLASH_ON1_END   = PHASE_W'(100);
  localparam logic [PHASE_W-1:0] FLASH_ON2_START = PHASE_W'(200);
  localparam logic [PHASE_W-1:0] FLASH_ON2_END   = PHASE_W'(300);

  localparam logic [HALF_W-1:0] CHECK_INTERVAL_RST = HALF_W'(100);
  localparam logic [HALF_W-1:0] OK_HALF_RST        = HALF_W'(500);
  localparam logic [HALF_W-1:0] WARN_HALF_RST      = HALF_W'(100);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 3'd0,
    CMD_POS    = 3'd1,
    CMD_ESTOP  = 3'd2,
    CMD_RESET  = 3'd3,
    CMD_LIMITS = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_WARN = 2'd1,
    STATUS_STOP = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHECK_INTERVAL = 2'd0,
    REG_OK_HALF        = 2'd1,
    REG_WARN_HALF      = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] servo_index;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] limit_low;
    logic [POS_W-1:0] limit_high;
    logic             sweep_last;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                led;
    logic                beeper;
    logic                stop_servos;
    logic                watchdog_kick;
  } result_t;

  typedef struct packed {
    logic warn;
    logic err;
  } lim_chk_t;

  typedef struct packed {
    logic [HALF_W-1:0] check_interval;
    logic [HALF_W-1:0] ok_half_period;
    logic [HALF_W-1:0] warn_half_period;
  } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/sslsm_in_if.sv
// Request channel into the safety monitor: valid/ready plus one input item.
// Depends on sslsm_pkg for field widths.
`default_nettype none

interface sslsm_in_if;
  logic                         valid;
  logic                         ready;
  logic [sslsm_pkg::CMD_W-1:0]  cmd;
  logic [sslsm_pkg::IDX_W-1:0]  servo_index;
  logic [sslsm_pkg::POS_W-1:0]  position;
  logic [sslsm_pkg::POS_W-1:0]  limit_low;
  logic [sslsm_pkg::POS_W-1:0]  limit_high;
  logic                         sweep_last;

  modport source(
    output valid, cmd, servo_index, position, limit_low, limit_high, sweep_last,
    input  ready
  );
  modport sink(
    input  valid, cmd, servo_index, position, limit_low, limit_high, sweep_last,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/sslsm_out_if.sv
// Result channel out of the safety monitor: valid/ready plus one result.
// Depends on sslsm_pkg for field widths.
`default_nettype none

interface sslsm_out_if;
  logic                           valid;
  logic                           ready;
  logic [sslsm_pkg::STATUS_W-1:0] status;
  logic                           led;
  logic                           beeper;
  logic                           stop_servos;
  logic                           watchdog_kick;

  modport source(
    output valid, status, led, beeper, stop_servos, watchdog_kick,
    input  ready
  );
  modport sink(
    input  valid, status, led, beeper, stop_servos, watchdog_kick,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/sslsm_cfg_if.sv
// Register write channel of the safety monitor: valid/ready, index and data.
// Depends on sslsm_pkg for field widths.
`default_nettype none

interface sslsm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sslsm_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [sslsm_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, reg_index, data, input ready);
  modport sink(input valid, reg_index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sslsm_limits.sv
// Per-servo soft-limit table: clamped limit writes and window/error classification.
// Depends on sslsm_pkg.
`default_nettype none

module sslsm_limits (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [sslsm_pkg::IDX_W-1:0]   servo_index,
  input  wire logic [sslsm_pkg::POS_W-1:0]   position,
  input  wire logic [sslsm_pkg::POS_W-1:0]   limit_low,
  input  wire logic [sslsm_pkg::POS_W-1:0]   limit_high,
  output sslsm_pkg::lim_chk_t                chk
);

  logic [sslsm_pkg::LIMIT_W-1:0] low_r  [sslsm_pkg::SERVO_COUNT];
  logic [sslsm_pkg::LIMIT_W-1:0] high_r [sslsm_pkg::SERVO_COUNT];

  logic [sslsm_pkg::LIMIT_W-1:0] sel_lo;
  logic [sslsm_pkg::LIMIT_W-1:0] sel_hi;
  logic                          hit;
  logic [sslsm_pkg::POS_W-1:0]   lo_c;
  logic [sslsm_pkg::POS_W-1:0]   hi_c;
  logic                          wr_ok;
  logic                          outside;
  logic [sslsm_pkg::PROD_W-1:0]  pos_prod;
  logic [sslsm_pkg::PROD_W-1:0]  pos1_prod;
  logic [sslsm_pkg::PROD_W-1:0]  lo_prod;
  logic [sslsm_pkg::PROD_W-1:0]  hi_prod;
  logic                          err_hit;

  always_comb begin
    sel_lo = sslsm_pkg::LIMIT_FLOOR[sslsm_pkg::LIMIT_W-1:0];
    sel_hi = sslsm_pkg::LIMIT_CEIL[sslsm_pkg::LIMIT_W-1:0];
    hit    = 1'b0;
    for (int i = 0; i < sslsm_pkg::SERVO_COUNT; i++) begin
      if (servo_index == sslsm_pkg::IDX_W'(i)) begin
        sel_lo = low_r[i];
        sel_hi = high_r[i];
        hit    = 1'b1;
      end
    end
  end

  // clamp to the legal range, drop empty or inverted windows
  assign lo_c  = (limit_low < sslsm_pkg::LIMIT_FLOOR) ? sslsm_pkg::LIMIT_FLOOR : limit_low;
  assign hi_c  = (limit_high > sslsm_pkg::LIMIT_CEIL) ? sslsm_pkg::LIMIT_CEIL : limit_high;
  assign wr_ok = wr_en && hit && (lo_c < hi_c);

  // pos < floor(lo*80/100)  <=>  100*(pos+1) <= 80*lo
  // pos > floor(hi*120/100) <=>  120*hi < 100*pos
  assign outside   = (position < sslsm_pkg::POS_W'(sel_lo)) ||
                     (position > sslsm_pkg::POS_W'(sel_hi));
  assign pos_prod  = sslsm_pkg::PROD_W'(position) * sslsm_pkg::PROD_W'(sslsm_pkg::PCT_SCALE);
  assign pos1_prod = pos_prod + sslsm_pkg::PROD_W'(sslsm_pkg::PCT_SCALE);
  assign lo_prod   = sslsm_pkg::PROD_W'(sel_lo) * sslsm_pkg::PROD_W'(sslsm_pkg::ERR_LOW_PCT);
  assign hi_prod   = sslsm_pkg::PROD_W'(sel_hi) * sslsm_pkg::PROD_W'(sslsm_pkg::ERR_HIGH_PCT);
  assign err_hit   = (pos1_prod <= lo_prod) || (hi_prod < pos_prod);

  assign chk.err  = hit && outside && err_hit;
  assign chk.warn = hit && outside && !err_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sslsm_pkg::SERVO_COUNT; i++) begin
        low_r[i]  <= sslsm_pkg::LIMIT_FLOOR[sslsm_pkg::LIMIT_W-1:0];
        high_r[i] <= sslsm_pkg::LIMIT_CEIL[sslsm_pkg::LIMIT_W-1:0];
      end
    end else if (wr_ok) begin
      for (int i = 0; i < sslsm_pkg::SERVO_COUNT; i++) begin
        if (servo_index == sslsm_pkg::IDX_W'(i)) begin
          low_r[i]  <= lo_c[sslsm_pkg::LIMIT_W-1:0];
          high_r[i] <= hi_c[sslsm_pkg::LIMIT_W-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sslsm_core.sv
// Monitor state: tick counters, check scheduling, stop latch, status and LED pattern.
// Depends on sslsm_pkg; takes the limit classification from sslsm_limits.
`default_nettype none

module sslsm_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire sslsm_pkg::item_t    item,
  input  wire sslsm_pkg::lim_chk_t chk,
  input  wire sslsm_pkg::cfg_t     cfg,
  output sslsm_pkg::result_t       res
);

  logic [sslsm_pkg::TICK_W-1:0]  elapsed_r, elapsed_nxt;
  logic [sslsm_pkg::TICK_W-1:0]  since_chk_r, since_chk_nxt;
  logic [sslsm_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic                          blink_r, blink_nxt;
  logic                          led_r, led_nxt;
  logic                          beeper_r, beeper_nxt;
  logic                          stopped_r, stopped_nxt;
  sslsm_pkg::status_t            status_r, status_nxt;
  logic                          sw_warn_r, sw_warn_nxt;
  logic                          sw_err_r, sw_err_nxt;

  logic                          stop_pulse;
  logic                          kick_pulse;
  logic                          do_led;
  logic                          sw_warn_acc;
  logic                          sw_err_acc;
  logic                          due;
  logic [sslsm_pkg::HALF_W-1:0]  half;

  assign sw_warn_acc = sw_warn_r | chk.warn;
  assign sw_err_acc  = sw_err_r | chk.err;
  assign due         = (since_chk_r >= sslsm_pkg::TICK_W'(cfg.check_interval)) && !stopped_r;

  always_comb begin
    elapsed_nxt   = elapsed_r;
    since_chk_nxt = since_chk_r;
    phase_nxt     = phase_r;
    blink_nxt     = blink_r;
    led_nxt       = led_r;
    beeper_nxt    = beeper_r;
    stopped_nxt   = stopped_r;
    status_nxt    = status_r;
    sw_warn_nxt   = sw_warn_r;
    sw_err_nxt    = sw_err_r;
    stop_pulse    = 1'b0;
    kick_pulse    = 1'b0;
    do_led        = 1'b0;
    half          = cfg.ok_half_period;

    case (item.cmd)
      sslsm_pkg::CMD_TICK: begin
        elapsed_nxt   = elapsed_r + 1'b1;
        since_chk_nxt = since_chk_r + 1'b1;
        // flash phase tracks elapsed mod 1000, restarting when elapsed wraps
        if (elapsed_nxt == '0 || phase_r == sslsm_pkg::FLASH_PERIOD - 1'b1) begin
          phase_nxt = '0;
        end else begin
          phase_nxt = phase_r + 1'b1;
        end
        do_led = 1'b1;
      end
      sslsm_pkg::CMD_POS: begin
        if (item.sweep_last) begin
          if (due) begin
            if (sw_err_acc) begin
              stopped_nxt = 1'b1;
              status_nxt  = sslsm_pkg::STATUS_STOP;
              beeper_nxt  = 1'b1;
              stop_pulse  = 1'b1;
            end else if (sw_warn_acc) begin
              status_nxt = sslsm_pkg::STATUS_WARN;
            end else if (status_r == sslsm_pkg::STATUS_WARN) begin
              status_nxt = sslsm_pkg::STATUS_OK;
            end
            kick_pulse    = 1'b1;
            since_chk_nxt = '0;
          end
          sw_warn_nxt = 1'b0;
          sw_err_nxt  = 1'b0;
        end else begin
          sw_warn_nxt = sw_warn_acc;
          sw_err_nxt  = sw_err_acc;
        end
        do_led = 1'b1;
      end
      sslsm_pkg::CMD_ESTOP: begin
        stopped_nxt = 1'b1;
        status_nxt  = sslsm_pkg::STATUS_STOP;
        beeper_nxt  = 1'b1;
        stop_pulse  = 1'b1;
      end
      sslsm_pkg::CMD_RESET: begin
        stopped_nxt = 1'b0;
        status_nxt  = sslsm_pkg::STATUS_OK;
        beeper_nxt  = 1'b0;
        led_nxt     = 1'b0;
      end
      default: begin
      end
    endcase

    if (do_led) begin
      if (status_nxt == sslsm_pkg::STATUS_STOP) begin
        led_nxt = (phase_nxt < sslsm_pkg::FLASH_ON1_END) ||
                  ((phase_nxt >= sslsm_pkg::FLASH_ON2_START) &&
                   (phase_nxt < sslsm_pkg::FLASH_ON2_END));
      end else begin
        if (status_nxt == sslsm_pkg::STATUS_WARN) begin
          half = cfg.warn_half_period;
        end
        if (elapsed_nxt >= sslsm_pkg::TICK_W'(half)) begin
          blink_nxt   = !blink_r;
          led_nxt     = !blink_r;
          elapsed_nxt = '0;
          phase_nxt   = '0;
        end
      end
    end
  end

  assign res.status        = status_nxt;
  assign res.led           = led_nxt;
  assign res.beeper        = beeper_nxt;
  assign res.stop_servos   = stop_pulse;
  assign res.watchdog_kick = kick_pulse;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r   <= '0;
      since_chk_r <= '0;
      phase_r     <= '0;
      blink_r     <= 1'b0;
      led_r       <= 1'b0;
      beeper_r    <= 1'b0;
      stopped_r   <= 1'b0;
      status_r    <= sslsm_pkg::STATUS_OK;
      sw_warn_r   <= 1'b0;
      sw_err_r    <= 1'b0;
    end else if (adv) begin
      elapsed_r   <= elapsed_nxt;
      since_chk_r <= since_chk_nxt;
      phase_r     <= phase_nxt;
      blink_r     <= blink_nxt;
      led_r       <= led_nxt;
      beeper_r    <= beeper_nxt;
      stopped_r   <= stopped_nxt;
      status_r    <= status_nxt;
      sw_warn_r   <= sw_warn_nxt;
      sw_err_r    <= sw_err_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/servo_soft_limit_safety_monitor.sv
// Servo soft-limit safety monitor: top level with request/result registers and config.
// Depends on sslsm_pkg, sslsm_in_if, sslsm_out_if, sslsm_cfg_if, sslsm_limits, sslsm_core.
//
// Usage:
//   in_if   request channel: tick, position sample, emergency stop, reset or
//           limit write, one request per valid/ready handshake.
//   out_if  result channel: exactly one result per request, in request order.
//   cfg_if  register writes (check interval, OK and warning blink half
//           periods); always ready, write only while the block is idle.
// Timing: a request accepted at a clock edge is held in the request register;
// its result is formed combinationally and loaded into the output register
// when the request advances, which waits while a held result is not taken.
// Throughput: one request per clock while out_if.ready is high, with a
// combinational state update between the request and output registers.
// Reset (rst_n low, synchronous): both pipeline registers empty, status OK,
// LED and beeper off, all limits 500..2500, registers at their reset values.
// Receiver stall: the output register holds its result; one more request is
// taken into the request register, then in_if.ready drops until out_if.ready.
`default_nettype none

module servo_soft_limit_safety_monitor (
  input wire logic   clk,
  input wire logic   rst_n,
  sslsm_in_if.sink   in_if,
  sslsm_out_if.source out_if,
  sslsm_cfg_if.sink  cfg_if
);

  logic                  s1_valid_r, s1_valid_nxt;
  sslsm_pkg::item_t      s1_item_r;
  logic                  out_valid_r, out_valid_nxt;
  sslsm_pkg::result_t    out_res_r;
  sslsm_pkg::cfg_t       cfg_r;
  sslsm_pkg::lim_chk_t   chk;
  sslsm_pkg::result_t    res;
  logic                  adv;
  logic                  in_acc;

  assign adv           = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready   = !s1_valid_r || adv;
  assign in_acc        = in_if.valid && in_if.ready;
  assign s1_valid_nxt  = in_acc || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && !out_if.ready);
  assign cfg_if.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.cmd         <= in_if.cmd;
      s1_item_r.servo_index <= in_if.servo_index;
      s1_item_r.position    <= in_if.position;
      s1_item_r.limit_low   <= in_if.limit_low;
      s1_item_r.limit_high  <= in_if.limit_high;
      s1_item_r.sweep_last  <= in_if.sweep_last;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_interval   <= sslsm_pkg::CHECK_INTERVAL_RST;
      cfg_r.ok_half_period   <= sslsm_pkg::OK_HALF_RST;
      cfg_r.warn_half_period <= sslsm_pkg::WARN_HALF_RST;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.reg_index)
        sslsm_pkg::REG_CHECK_INTERVAL: cfg_r.check_interval   <= cfg_if.data;
        sslsm_pkg::REG_OK_HALF:        cfg_r.ok_half_period   <= cfg_if.data;
        sslsm_pkg::REG_WARN_HALF:      cfg_r.warn_half_period <= cfg_if.data;
        default: begin
        end
      endcase
    end
  end

  sslsm_limits u_limits (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (adv && (s1_item_r.cmd == sslsm_pkg::CMD_LIMITS)),
    .servo_index (s1_item_r.servo_index),
    .position    (s1_item_r.position),
    .limit_low   (s1_item_r.limit_low),
    .limit_high  (s1_item_r.limit_high),
    .chk         (chk)
  );

  sslsm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (s1_item_r),
    .chk   (chk),
    .cfg   (cfg_r),
    .res   (res)
  );

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = out_res_r.status;
  assign out_if.led           = out_res_r.led;
  assign out_if.beeper        = out_res_r.beeper;
  assign out_if.stop_servos   = out_res_r.stop_servos;
  assign out_if.watchdog_kick = out_res_r.watchdog_kick;

  a_adv_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_if.valid)
    else $error("advanced request did not reach the output register");

  a_stop_implies_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.stop_servos) |->
      (out_if.status == sslsm_pkg::STATUS_STOP) && out_if.beeper)
    else $error("stop pulse without stopped status and beeper");

  a_beeper_tracks_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.beeper == (out_if.status == sslsm_pkg::STATUS_STOP)))
    else $error("beeper level disagrees with stopped status");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_if.ready)
    else $error("request refused while request register is empty");

endmodule

`default_nettype wire
